// ----- rtl/kalman_filter_2d_position_unit_defines.svh -----
// Assertion macros for the 2-D position Kalman filter.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef KALMAN_FILTER_2D_POSITION_UNIT_DEFINES_SVH
`define KALMAN_FILTER_2D_POSITION_UNIT_DEFINES_SVH

// same-cycle implication
`define KF2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KF2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kf2d_pkg.sv -----
// Package for the 2-D position Kalman filter: item types, register codes,
// reset values, step numbering of the sequencer. No dependencies.
`default_nettype none

package kf2d_pkg;

	localparam int ACC_W = 128;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] meas_east;
		logic signed [31:0] meas_north;
		logic signed [31:0] drive_east;
		logic signed [31:0] drive_north;
	} kf2d_in_t;

	typedef struct packed {
		logic signed [31:0] est_east;
		logic signed [31:0] est_north;
		logic signed [47:0] cov_00;
		logic signed [47:0] cov_01;
		logic signed [47:0] cov_10;
		logic signed [47:0] cov_11;
		logic               singular;
	} kf2d_out_t;

	typedef enum logic [2:0] {
		CFG_TRANSITION  = 3'd0,
		CFG_OBSERVATION = 3'd1,
		CFG_PROC_NOISE  = 3'd2,
		CFG_MEAS_NOISE  = 3'd3,
		CFG_INIT_POS    = 3'd4,
		CFG_INIT_COV    = 3'd5
	} kf2d_cfg_idx_t;

	localparam logic [63:0] RST_TRANSITION  = 64'd1152921504606851072;
	localparam logic [63:0] RST_OBSERVATION = 64'd1152921504606851072;
	localparam logic [63:0] RST_PROC_NOISE  = 64'd450359962737051200;
	localparam logic [63:0] RST_MEAS_NOISE  = 64'd112589990684262800;
	localparam logic [63:0] RST_INIT_POS    = 64'd2621440;
	localparam logic [63:0] RST_INIT_COV    = 64'd45035996273705120;

	localparam logic signed [47:0] RST_COV_DIAG = 48'sd167772160;
	localparam logic signed [31:0] RST_POS_EAST = 32'sd2621440;

	localparam logic [5:0] D_CP   = 6'd0;
	localparam logic [5:0] D_M    = 6'd4;
	localparam logic [5:0] D_S    = 6'd8;
	localparam logic [5:0] D_DET  = 6'd12;
	localparam logic [5:0] D_KG   = 6'd13;
	localparam logic [5:0] D_YT   = 6'd17;
	localparam logic [5:0] D_XU   = 6'd19;
	localparam logic [5:0] D_GU   = 6'd21;
	localparam logic [5:0] D_AG   = 6'd25;
	localparam logic [5:0] D_PN   = 6'd29;
	localparam logic [5:0] D_POS  = 6'd33;
	localparam logic [5:0] D_LAST = 6'd34;

	function automatic logic signed [15:0] ent16(input logic [63:0] r, input logic [1:0] k);
		logic signed [15:0] v;
		case (k)
			2'd0:    v = r[15:0];
			2'd1:    v = r[31:16];
			2'd2:    v = r[47:32];
			default: v = r[63:48];
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/kalman_filter_2d_position_unit.sv -----
// Top level of the 2-D position Kalman filter: sequencer around one shared
// multiply-accumulate unit and a bit-serial divider. Uses kf2d_pkg and the defines header.
//
// channel | signals                        | use
// meas    | meas_valid, meas_ready, meas   | one step or restart item in
// est     | est_valid, est_ready, est      | one estimate item out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// A filter step runs 35 dot steps on one 49x17 multiplier, taking the second term
// 16 bits at a time, and each of the four gain entries also passes through the divider;
// a zero determinant skips the correction dots, and a restart runs no dots. A new item
// is taken only once the last one has finished and its result has gone to the output.
// Reset loads the register defaults and the restart state. A result waits in the output
// register; the next item may run meanwhile and holds at its end until the first is taken.
`default_nettype none
`include "kalman_filter_2d_position_unit_defines.svh"

module kalman_filter_2d_position_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               meas_valid,
	output logic                    meas_ready,
	input  wire kf2d_pkg::kf2d_in_t meas,
	output logic                    est_valid,
	input  wire logic               est_ready,
	output kf2d_pkg::kf2d_out_t     est,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);
	import kf2d_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_ACC, ST_CHK, ST_DIVS, ST_DIVE, ST_FIN
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [63:0] a_q, c_q, qn_q, rn_q, ipos_q, icov_q;
	logic signed [47:0] p_q [4];
	logic signed [31:0] x_q [2];
	logic signed [47:0] cp_q [4];
	logic signed [47:0] m_q [4];
	logic signed [47:0] s_q [4];
	logic signed [31:0] kg_q [4];
	logic signed [31:0] yt_q [2];
	logic signed [31:0] xu_q [2];
	logic signed [47:0] gu_q [4];
	logic signed [47:0] ag_q [4];
	logic signed [31:0] y_q [2];
	logic signed [31:0] u_q [2];
	logic signed [ACC_W-1:0] det_q, acc_q;
	logic signed [65:0] prod_q;
	logic [ACC_W-1:0] nq_q, rem_q;
	logic [6:0] cnt_q;
	logic [5:0] idx_q;
	logic       term_q;
	logic [1:0] dig_q;
	logic       qneg_q, sing_q, est_valid_q;
	kf2d_out_t  est_q;

	logic signed [48:0] a_op;
	logic signed [47:0] b_op;
	logic [1:0] dlast;
	logic signed [ACC_W-1:0] extra;
	logic [4:0] sh;
	logic       is_div;
	logic [5:0] off;
	logic       gi, gj, t;

	always_comb begin
		a_op = '0; b_op = '0; dlast = 2'd0; extra = '0; sh = 5'd12;
		is_div = 1'b0; t = term_q;
		off = '0; gi = 1'b0; gj = 1'b0;
		case (idx_q) inside
			[D_CP:D_CP+3]: begin
				off = idx_q - D_CP; gi = off[1]; gj = off[0];
				a_op = 49'(p_q[{t, gj}]);
				b_op = 48'(ent16(c_q, {gi, t}));
			end
			[D_M:D_M+3]: begin
				off = idx_q - D_M; gi = off[1]; gj = off[0];
				a_op = 49'(p_q[{gi, t}]);
				b_op = 48'(ent16(c_q, {gj, t}));
			end
			[D_S:D_S+3]: begin
				off = idx_q - D_S; gi = off[1]; gj = off[0];
				a_op = 49'(cp_q[{gi, t}]);
				b_op = 48'(ent16(c_q, {gj, t}));
				extra = ACC_W'(ent16(rn_q, {gi, gj})) <<< 32;
			end
			D_DET: begin
				a_op = t ? -49'(s_q[1]) : 49'(s_q[0]);
				b_op = t ? s_q[2] : s_q[3];
				dlast = 2'd2; sh = 5'd0;
			end
			[D_KG:D_KG+3]: begin
				off = idx_q - D_KG; gi = off[1]; gj = off[0];
				case ({t, gj})
					2'd0:    a_op = 49'(s_q[3]);
					2'd1:    a_op = -49'(s_q[1]);
					2'd2:    a_op = -49'(s_q[2]);
					default: a_op = 49'(s_q[0]);
				endcase
				b_op = m_q[{gi, t}];
				dlast = 2'd2; sh = 5'd0; is_div = 1'b1;
			end
			[D_YT:D_YT+1]: begin
				off = idx_q - D_YT; gi = off[0];
				a_op = -49'(x_q[t]);
				b_op = 48'(ent16(c_q, {gi, t}));
				extra = ACC_W'(y_q[gi]) <<< 12;
			end
			[D_XU:D_XU+1]: begin
				off = idx_q - D_XU; gi = off[0];
				a_op = 49'(kg_q[{gi, t}]);
				b_op = 48'(yt_q[t]);
				dlast = 2'd1; extra = ACC_W'(x_q[gi]) <<< 24; sh = 5'd24;
			end
			[D_GU:D_GU+3]: begin
				off = idx_q - D_GU; gi = off[1]; gj = off[0];
				a_op = -49'(kg_q[{gi, t}]);
				b_op = cp_q[{t, gj}];
				dlast = 2'd2; extra = ACC_W'(p_q[{gi, gj}]) <<< 24; sh = 5'd24;
			end
			[D_AG:D_AG+3]: begin
				off = idx_q - D_AG; gi = off[1]; gj = off[0];
				a_op = 49'(gu_q[{t, gj}]);
				b_op = 48'(ent16(a_q, {gi, t}));
			end
			[D_PN:D_PN+3]: begin
				off = idx_q - D_PN; gi = off[1]; gj = off[0];
				a_op = 49'(ag_q[{gi, t}]);
				b_op = 48'(ent16(a_q, {gj, t}));
				extra = ACC_W'(ent16(qn_q, {gi, gj})) <<< 32;
			end
			[D_POS:D_POS+1]: begin
				off = idx_q - D_POS; gi = off[0];
				a_op = 49'(xu_q[t]);
				b_op = 48'(ent16(a_q, {gi, t}));
				extra = ACC_W'(u_q[gi]) <<< 12;
			end
			default: ;
		endcase
	end

	logic [15:0] bs;
	logic signed [16:0] dsig;
	logic signed [65:0] prod;
	logic signed [ACC_W-1:0] shifted, half, rnd, num;
	logic signed [47:0] res48;
	logic signed [31:0] res32;
	logic [ACC_W-1:0] dmag;
	logic [ACC_W:0] trial;
	logic ge;

	always_comb begin
		case (dig_q)
			2'd0:    bs = b_op[15:0];
			2'd1:    bs = b_op[31:16];
			default: bs = b_op[47:32];
		endcase
		dsig = (dig_q == dlast) ? {bs[15], bs} : {1'b0, bs};
		prod = a_op * dsig;
		case (dig_q)
			2'd0:    shifted = ACC_W'(prod_q);
			2'd1:    shifted = ACC_W'(prod_q) <<< 16;
			default: shifted = ACC_W'(prod_q) <<< 32;
		endcase
		half = (sh == 5'd0) ? '0 : ACC_W'(1) <<< (sh - 5'd1);
		rnd = (acc_q + half) >>> sh;
		if ((&rnd[ACC_W-1:47]) || !(|rnd[ACC_W-1:47]))
			res48 = rnd[47:0];
		else
			res48 = rnd[ACC_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		if ((&rnd[ACC_W-1:31]) || !(|rnd[ACC_W-1:31]))
			res32 = rnd[31:0];
		else
			res32 = rnd[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		num = acc_q <<< 24;
		dmag = det_q[ACC_W-1] ? ACC_W'(-det_q) : det_q;
		trial = {rem_q, nq_q[ACC_W-1]};
		ge = trial >= {1'b0, dmag};
	end

	assign meas_ready = (state_q == ST_IDLE) && !done_q;
	assign cfg_ready  = 1'b1;
	assign est_valid  = est_valid_q;
	assign est        = est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			a_q <= RST_TRANSITION; c_q <= RST_OBSERVATION;
			qn_q <= RST_PROC_NOISE; rn_q <= RST_MEAS_NOISE;
			ipos_q <= RST_INIT_POS; icov_q <= RST_INIT_COV;
			p_q[0] <= RST_COV_DIAG; p_q[1] <= '0; p_q[2] <= '0; p_q[3] <= RST_COV_DIAG;
			x_q[0] <= RST_POS_EAST; x_q[1] <= '0;
			for (int k = 0; k < 4; k++) begin
				cp_q[k] <= '0; m_q[k] <= '0; s_q[k] <= '0; kg_q[k] <= '0;
				gu_q[k] <= '0; ag_q[k] <= '0;
			end
			for (int k = 0; k < 2; k++) begin
				yt_q[k] <= '0; xu_q[k] <= '0; y_q[k] <= '0; u_q[k] <= '0;
			end
			idx_q <= '0; term_q <= 1'b0; dig_q <= '0; cnt_q <= '0;
			qneg_q <= 1'b0; sing_q <= 1'b0; est_valid_q <= 1'b0;
			est_q <= '0; acc_q <= '0; prod_q <= '0; det_q <= '0;
			nq_q <= '0; rem_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TRANSITION:  a_q <= cfg_data;
					CFG_OBSERVATION: c_q <= cfg_data;
					CFG_PROC_NOISE:  qn_q <= cfg_data;
					CFG_MEAS_NOISE:  rn_q <= cfg_data;
					CFG_INIT_POS:    ipos_q <= cfg_data;
					CFG_INIT_COV:    icov_q <= cfg_data;
					default: ;
				endcase
			end
			if (done_q && (!est_valid_q || est_ready)) begin
				est_q <= {x_q[0], x_q[1], p_q[0], p_q[1], p_q[2], p_q[3], sing_q};
				est_valid_q <= 1'b1;
				done_q <= 1'b0;
			end else if (est_valid_q && est_ready) begin
				est_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (meas_valid && meas_ready) begin
						sing_q <= 1'b0;
						if (meas.operation) begin
							x_q[0] <= ipos_q[31:0];
							x_q[1] <= ipos_q[63:32];
							for (int k = 0; k < 4; k++)
								p_q[k] <= 48'(ent16(icov_q, 2'(k))) <<< 20;
							done_q <= 1'b1;
						end else begin
							y_q[0] <= meas.meas_east; y_q[1] <= meas.meas_north;
							u_q[0] <= meas.drive_east; u_q[1] <= meas.drive_north;
							idx_q <= D_CP;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					acc_q <= extra;
					term_q <= 1'b0;
					dig_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= prod;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + shifted;
					if (dig_q != dlast) begin
						dig_q <= dig_q + 2'd1;
						state_q <= ST_MUL;
					end else if (!term_q) begin
						term_q <= 1'b1;
						dig_q <= '0;
						state_q <= ST_MUL;
					end else if (idx_q == D_DET) begin
						det_q <= acc_q + shifted;
						state_q <= ST_CHK;
					end else if (is_div) begin
						state_q <= ST_DIVS;
					end else begin
						state_q <= ST_FIN;
					end
					cnt_q <= '0;
					rem_q <= '0;
				end
				ST_CHK: begin
					if (det_q == '0) begin
						sing_q <= 1'b1;
						for (int k = 0; k < 4; k++) gu_q[k] <= p_q[k];
						xu_q[0] <= x_q[0];
						xu_q[1] <= x_q[1];
						idx_q <= D_AG;
					end else begin
						idx_q <= D_KG;
					end
					state_q <= ST_LOAD;
				end
				ST_DIVS: begin
					if (cnt_q == '0) begin
						// first cycle: load the dividend magnitude
						nq_q <= num[ACC_W-1] ? ACC_W'(-num) : num;
						qneg_q <= num[ACC_W-1] ^ det_q[ACC_W-1];
						cnt_q <= 7'd1;
					end else begin
						rem_q <= ge ? ACC_W'(trial - {1'b0, dmag}) : trial[ACC_W-1:0];
						nq_q <= {nq_q[ACC_W-2:0], ge};
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd127)
							state_q <= ST_DIVE;
					end
				end
				ST_DIVE: begin
					// last shift-in of the quotient happens here
					rem_q <= ge ? ACC_W'(trial - {1'b0, dmag}) : trial[ACC_W-1:0];
					acc_q <= qneg_q ? -$signed({nq_q[ACC_W-2:0], ge})
						: $signed({nq_q[ACC_W-2:0], ge});
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					case (idx_q) inside
						[D_CP:D_CP+3]:   cp_q[off[1:0]] <= res48;
						[D_M:D_M+3]:     m_q[off[1:0]] <= res48;
						[D_S:D_S+3]:     s_q[off[1:0]] <= res48;
						[D_KG:D_KG+3]:   kg_q[off[1:0]] <= res32;
						[D_YT:D_YT+1]:   yt_q[off[0]] <= res32;
						[D_XU:D_XU+1]:   xu_q[off[0]] <= res32;
						[D_GU:D_GU+3]:   gu_q[off[1:0]] <= res48;
						[D_AG:D_AG+3]:   ag_q[off[1:0]] <= res48;
						[D_PN:D_PN+3]:   p_q[off[1:0]] <= res48;
						[D_POS:D_POS+1]: x_q[off[0]] <= res32;
						default: ;
					endcase
					if (idx_q == D_LAST) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 6'd1;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`KF2D_ASSERT_NEXT(a_step_starts, meas_valid && meas_ready && !meas.operation, state_q == ST_LOAD && idx_q == D_CP, "step did not start at first dot")
	`KF2D_ASSERT_NEXT(a_singular_skip, state_q == ST_CHK && det_q == '0, sing_q && idx_q == D_AG, "zero determinant did not skip correction")
	`KF2D_ASSERT_NEXT(a_last_dot_done, state_q == ST_FIN && idx_q == D_LAST, done_q && state_q == ST_IDLE, "last dot did not finish the step")
	`KF2D_ASSERT_NOW(a_no_accept_pending, done_q, !meas_ready, "item accepted while a result is pending")

endmodule

`default_nettype wire
